FILE: rtl/rht_pkg.sv
// Shared types, constants and fixed-point helpers for the hue rotation tetrad.
// No dependencies; rht_rot, the top level and rht_chk import this package.
`timescale 1ns / 1ps

package rht_pkg;

    typedef struct packed {
        logic [7:0] base_red;
        logic [7:0] base_green;
        logic [7:0] base_blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] first_red;
        logic [7:0] first_green;
        logic [7:0] first_blue;
        logic [7:0] second_red;
        logic [7:0] second_green;
        logic [7:0] second_blue;
        logic [7:0] third_red;
        logic [7:0] third_green;
        logic [7:0] third_blue;
    } tetrad_t;

    typedef enum logic [1:0] {
        REG_SHIFT_FIRST  = 2'd0,
        REG_SHIFT_SECOND = 2'd1,
        REG_SHIFT_THIRD  = 2'd2
    } cfg_reg_t;

    localparam logic [16:0] HUE_SECTOR = 17'd15360;
    localparam logic [16:0] HUE_FULL   = 17'd92160;
    localparam logic [8:0]  DEG_FULL   = 9'd360;
    localparam logic [20:0] RECIP15    = 21'd1118482;

    localparam int HUE_QW     = 17;
    localparam int HUE_NW     = 25;
    localparam int SAT_NW     = 24;
    localparam int ROT_STAGES = 8;
    localparam int PIPE_LAT   = HUE_QW + ROT_STAGES + 1;

    // floor(p / 65535) for p up to 65535 * 65535
    function automatic logic [15:0] frac_div(input logic [31:0] p);
        logic [32:0] s;
        s = {1'b0, p} + {17'd0, p[31:16]} + 33'd1;
        return s[31:16];
    endfunction

    // floor(x / 257)
    function automatic logic [7:0] div257(input logic [15:0] x);
        logic [23:0] s;
        s = ({8'd0, x} * 24'd255) + 24'd255;
        return s[23:16];
    endfunction

endpackage

FILE: rtl/rht_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Depends on nothing; used by the top level for hue and saturation.
`timescale 1ns / 1ps

module rht_div #(
    parameter int N_W   = 25,
    parameter int DEN_W = 8,
    parameter int Q_W   = 17,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [N_W-1:0]   numer,
    input  logic [DEN_W-1:0] denom,
    input  logic [TAG_W-1:0] tag,
    output logic             fin,
    output logic [Q_W-1:0]   quot,
    output logic [TAG_W-1:0] fin_tag
);

    logic [Q_W:0]       v_reg;
    logic [DEN_W-1:0]   rem_reg [Q_W+1];
    logic [Q_W-1:0]     q_reg   [Q_W+1];
    logic [N_W-1:0]     num_reg [Q_W+1];
    logic [DEN_W-1:0]   den_reg [Q_W+1];
    logic [TAG_W-1:0]   tag_reg [Q_W+1];
    logic [N_W-1:0]     top_bits;

    assign top_bits = numer >> Q_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[Q_W-1:0], go};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= top_bits[DEN_W-1:0];
        q_reg[0]   <= '0;
        num_reg[0] <= numer;
        den_reg[0] <= denom;
        tag_reg[0] <= tag;
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W:0]   diff;
        logic [DEN_W-1:0] rem_next;
        logic [Q_W-1:0]   q_next;

        always_comb
        begin
            trial    = {rem_reg[k], num_reg[k][Q_W-1-k]};
            ge       = trial >= {1'b0, den_reg[k]};
            diff     = trial - {1'b0, den_reg[k]};
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_next   = q_reg[k];
            q_next[Q_W-1-k] = ge;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= rem_next;
            q_reg[k+1]   <= q_next;
            num_reg[k+1] <= num_reg[k];
            den_reg[k+1] <= den_reg[k];
            tag_reg[k+1] <= tag_reg[k];
        end
    end

    assign fin     = v_reg[Q_W];
    assign quot    = q_reg[Q_W];
    assign fin_tag = tag_reg[Q_W];

endmodule

FILE: rtl/rht_rot.sv
// Eight-stage pipeline: rotate one hue, convert HSV back to 8-bit RGB.
// Depends on rht_pkg.
`timescale 1ns / 1ps

module rht_rot (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [16:0] hue,
    input  logic [8:0]  shift,
    input  logic [15:0] sat,
    input  logic [7:0]  maxc,
    input  logic        grey,
    output logic        fin,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);
    import rht_pkg::*;

    typedef enum logic [2:0] {
        SEC_0, SEC_1, SEC_2, SEC_3, SEC_4, SEC_5
    } sector_t;

    logic [ROT_STAGES:1] v_reg;

    logic [16:0] h_reg;
    logic [15:0] sat1_reg, sat2_reg, sat3_reg;
    logic [7:0]  mx1_reg, mx2_reg, mx3_reg, mx4_reg, mx5_reg, mx6_reg, mx7_reg;
    logic        g1_reg, g2_reg, g3_reg, g4_reg, g5_reg, g6_reg, g7_reg;
    sector_t     sec2_reg, sec3_reg, sec4_reg, sec5_reg, sec6_reg;
    logic [19:0] y_reg;
    logic [15:0] f_reg, oms_reg;
    logic [31:0] pm_reg, ps1_reg, ps2_reg, pn_reg, pk_reg;
    logic [15:0] m_reg, a1_reg, a2_reg, m6_reg;
    logic [15:0] cr_reg, cg_reg, cb_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;

    logic [17:0] sum;
    logic [17:0] sum_wrap;
    logic [16:0] h_next;
    sector_t     sec_next;
    logic [16:0] base;
    logic [16:0] rem17;
    logic [29:0] scaled;
    logic [40:0] fprod;
    logic [15:0] val3, val5;
    logic [15:0] n_val, k_val;
    logic [15:0] cr_next, cg_next, cb_next;

    always_comb
    begin
        sum      = {1'b0, hue} + {1'b0, shift, 8'd0};
        sum_wrap = sum - {1'b0, HUE_FULL};
        h_next   = (sum >= {1'b0, HUE_FULL}) ? sum_wrap[16:0] : sum[16:0];
    end

    always_comb
    begin
        priority if (h_reg < HUE_SECTOR)
        begin
            sec_next = SEC_0;
            base     = 17'd0;
        end
        else if (h_reg < 17'd30720)
        begin
            sec_next = SEC_1;
            base     = 17'd15360;
        end
        else if (h_reg < 17'd46080)
        begin
            sec_next = SEC_2;
            base     = 17'd30720;
        end
        else if (h_reg < 17'd61440)
        begin
            sec_next = SEC_3;
            base     = 17'd46080;
        end
        else if (h_reg < 17'd76800)
        begin
            sec_next = SEC_4;
            base     = 17'd61440;
        end
        else
        begin
            sec_next = SEC_5;
            base     = 17'd76800;
        end
        rem17  = h_reg - base;
        scaled = {rem17[13:0], 16'd0} - {16'd0, rem17[13:0]};
    end

    assign fprod = {21'd0, y_reg} * {20'd0, RECIP15};
    assign val3  = {mx3_reg, mx3_reg};
    assign val5  = {mx5_reg, mx5_reg};

    always_comb
    begin
        n_val = frac_div(pn_reg);
        k_val = frac_div(pk_reg);
        unique case (sec6_reg)
            SEC_0:
            begin
                cr_next = {mx6_reg, mx6_reg}; cg_next = k_val; cb_next = m6_reg;
            end
            SEC_1:
            begin
                cr_next = n_val; cg_next = {mx6_reg, mx6_reg}; cb_next = m6_reg;
            end
            SEC_2:
            begin
                cr_next = m6_reg; cg_next = {mx6_reg, mx6_reg}; cb_next = k_val;
            end
            SEC_3:
            begin
                cr_next = m6_reg; cg_next = n_val; cb_next = {mx6_reg, mx6_reg};
            end
            SEC_4:
            begin
                cr_next = k_val; cg_next = m6_reg; cb_next = {mx6_reg, mx6_reg};
            end
            default:
            begin
                cr_next = {mx6_reg, mx6_reg}; cg_next = m6_reg; cb_next = n_val;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[ROT_STAGES-1:1], go};
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        sat1_reg <= sat;
        mx1_reg  <= maxc;
        g1_reg   <= grey;

        sec2_reg <= sec_next;
        y_reg    <= scaled[29:10];
        sat2_reg <= sat1_reg;
        mx2_reg  <= mx1_reg;
        g2_reg   <= g1_reg;

        f_reg    <= fprod[39:24];
        oms_reg  <= ~sat2_reg;
        sec3_reg <= sec2_reg;
        sat3_reg <= sat2_reg;
        mx3_reg  <= mx2_reg;
        g3_reg   <= g2_reg;

        pm_reg   <= {16'd0, val3} * {16'd0, oms_reg};
        ps1_reg  <= {16'd0, sat3_reg} * {16'd0, f_reg};
        ps2_reg  <= {16'd0, sat3_reg} * {16'd0, ~f_reg};
        sec4_reg <= sec3_reg;
        mx4_reg  <= mx3_reg;
        g4_reg   <= g3_reg;

        m_reg    <= frac_div(pm_reg);
        a1_reg   <= frac_div(ps1_reg);
        a2_reg   <= frac_div(ps2_reg);
        sec5_reg <= sec4_reg;
        mx5_reg  <= mx4_reg;
        g5_reg   <= g4_reg;

        pn_reg   <= {16'd0, val5} * {16'd0, ~a1_reg};
        pk_reg   <= {16'd0, val5} * {16'd0, ~a2_reg};
        m6_reg   <= m_reg;
        sec6_reg <= sec5_reg;
        mx6_reg  <= mx5_reg;
        g6_reg   <= g5_reg;

        cr_reg   <= cr_next;
        cg_reg   <= cg_next;
        cb_reg   <= cb_next;
        mx7_reg  <= mx6_reg;
        g7_reg   <= g6_reg;

        red_reg   <= g7_reg ? mx7_reg : div257(cr_reg);
        green_reg <= g7_reg ? mx7_reg : div257(cg_reg);
        blue_reg  <= g7_reg ? mx7_reg : div257(cb_reg);
    end

    assign fin   = v_reg[ROT_STAGES];
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

FILE: rtl/rgb_hue_rotation_tetrad.sv
// Top level of the hue rotation tetrad: config registers, HSV front end, three rotators.
// Depends on rht_pkg, rht_div and rht_rot.
`timescale 1ns / 1ps

// Takes one RGB pixel per clock (busy stays low) and returns three hue-rotated
// colors together, strobed by done. The pixel passes through the 18-stage hue
// and saturation dividers (an input stage plus 17 quotient bits), then through
// the 8-stage HSV-to-RGB pipeline. done is not held: the receiver must take each
// word in its cycle.
// Write shift registers only while no pixel is in flight.
module rgb_hue_rotation_tetrad (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rht_pkg::pixel_t  pixel,
    output logic             done,
    output rht_pkg::tetrad_t result,
    input  logic             wr_en,
    input  logic [1:0]       wr_index,
    input  logic [8:0]       wr_data
);
    import rht_pkg::*;

    logic [8:0]  shift_first_reg, shift_second_reg, shift_third_reg;
    logic [8:0]  shift_wr;
    logic [9:0]  shift_sub;

    logic [7:0]  r, g, b, mx, mn, dl;
    logic        grey;
    logic [11:0] num;
    logic [HUE_NW-1:0] hue_num;
    logic [SAT_NW-1:0] sat_num;
    logic [7:0]  hue_den, sat_den;

    logic              hue_fin;
    logic [HUE_QW-1:0] hue_q;
    logic [HUE_QW-1:0] sat_q;
    logic [7:0]        mx_q;
    logic              grey_q;
    logic [17:0]       hue_sub;
    logic [16:0]       hue_w;

    logic        fin1;
    logic [7:0]  r1, g1, b1, r2, g2, b2, r3, g3, b3;

    assign busy = 1'b0;

    assign shift_sub = {1'b0, wr_data} - {1'b0, DEG_FULL};
    assign shift_wr  = (wr_data >= DEG_FULL) ? shift_sub[8:0] : wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_first_reg  <= 9'd150;
            shift_second_reg <= 9'd180;
            shift_third_reg  <= 9'd330;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_SHIFT_FIRST:  shift_first_reg  <= shift_wr;
                REG_SHIFT_SECOND: shift_second_reg <= shift_wr;
                REG_SHIFT_THIRD:  shift_third_reg  <= shift_wr;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        r  = pixel.base_red;
        g  = pixel.base_green;
        b  = pixel.base_blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        dl   = mx - mn;
        grey = (mx == mn);
        priority if (r == mn)
            num = 12'd3 * {4'd0, dl} + {4'd0, b} - {4'd0, g};
        else if (b == mn)
            num = {4'd0, dl} + {4'd0, g} - {4'd0, r};
        else
            num = 12'd5 * {4'd0, dl} + {4'd0, r} - {4'd0, b};
        hue_num = grey ? '0 : {13'd0, num} * {8'd0, HUE_SECTOR};
        sat_num = grey ? '0 : {16'd0, dl} * 24'd65535;
        hue_den = grey ? 8'd1 : dl;
        sat_den = grey ? 8'd1 : mx;
    end

    rht_div #(
        .N_W   (HUE_NW),
        .DEN_W (8),
        .Q_W   (HUE_QW),
        .TAG_W (8)
    ) u_hue_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (start),
        .numer   (hue_num),
        .denom   (hue_den),
        .tag     (mx),
        .fin     (hue_fin),
        .quot    (hue_q),
        .fin_tag (mx_q)
    );

    rht_div #(
        .N_W   (SAT_NW),
        .DEN_W (8),
        .Q_W   (HUE_QW),
        .TAG_W (1)
    ) u_sat_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (start),
        .numer   (sat_num),
        .denom   (sat_den),
        .tag     (grey),
        .fin     (),
        .quot    (sat_q),
        .fin_tag (grey_q)
    );

    assign hue_sub = {1'b0, hue_q} - {1'b0, HUE_FULL};
    assign hue_w   = (hue_q >= HUE_FULL) ? hue_sub[16:0] : hue_q;

    rht_rot u_rot_first (
        .clk (clk), .rst_n (rst_n), .go (hue_fin), .hue (hue_w),
        .shift (shift_first_reg), .sat (sat_q[15:0]), .maxc (mx_q), .grey (grey_q),
        .fin (fin1), .red (r1), .green (g1), .blue (b1)
    );

    rht_rot u_rot_second (
        .clk (clk), .rst_n (rst_n), .go (hue_fin), .hue (hue_w),
        .shift (shift_second_reg), .sat (sat_q[15:0]), .maxc (mx_q), .grey (grey_q),
        .fin (), .red (r2), .green (g2), .blue (b2)
    );

    rht_rot u_rot_third (
        .clk (clk), .rst_n (rst_n), .go (hue_fin), .hue (hue_w),
        .shift (shift_third_reg), .sat (sat_q[15:0]), .maxc (mx_q), .grey (grey_q),
        .fin (), .red (r3), .green (g3), .blue (b3)
    );

    assign done = fin1;

    always_comb
    begin
        result.first_red    = r1;
        result.first_green  = g1;
        result.first_blue   = b1;
        result.second_red   = r2;
        result.second_green = g2;
        result.second_blue  = b2;
        result.third_red    = r3;
        result.third_green  = g3;
        result.third_blue   = b3;
    end

endmodule

FILE: rtl/rht_chk.sv
// Port-level checks for the hue rotation tetrad, bound to the top level.
// Depends on rht_pkg and rgb_hue_rotation_tetrad.
`timescale 1ns / 1ps

module rht_chk (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input rht_pkg::pixel_t  pixel,
    input logic             done,
    input rht_pkg::tetrad_t result
);
    import rht_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy) else $error("busy raised");

    a_done_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_LAT)) else $error("done without start");

    a_word_has_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_LAT done) else $error("word dropped");

    a_grey_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && pixel.base_red == pixel.base_green
               && pixel.base_red == pixel.base_blue)
        |-> ##PIPE_LAT (result.first_red == $past(pixel.base_red, PIPE_LAT)
            && result.second_green == $past(pixel.base_red, PIPE_LAT)
            && result.third_blue == $past(pixel.base_red, PIPE_LAT)))
        else $error("grey level changed");

endmodule

bind rgb_hue_rotation_tetrad rht_chk u_rht_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .pixel  (pixel),
    .done   (done),
    .result (result)
);
